>>> design/multi_servo_slew_limiter_macros.svh
// ----------------------------------------------------------------------------
// multi_servo_slew_limiter_macros.svh
// Assertion macros used by the servo slew limiter top module.
// ----------------------------------------------------------------------------
`ifndef MULTI_SERVO_SLEW_LIMITER_MACROS_SVH
`define MULTI_SERVO_SLEW_LIMITER_MACROS_SVH

`ifndef SYNTHESIS

`define MSL_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("multi_servo_slew_limiter: assertion failed");

`define MSL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("multi_servo_slew_limiter: assertion failed");

`else

`define MSL_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons)
`define MSL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

>>> design/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Types and constants of the multi-servo slew limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

	localparam int SERVO_COUNT_DEF = 6;
	localparam int MAX_SERVOS      = 6;
	localparam int POS_W           = 10;
	localparam int STEP_W          = 8;
	localparam int ID_W            = 3;
	localparam int KIND_W          = 2;
	localparam int LIM_TBL_W       = 60;
	localparam int STEP_TBL_W      = 48;
	localparam int APB_DATA_W      = 64;
	localparam int APB_ADDR_W      = 5;

	localparam logic [LIM_TBL_W-1:0]  MIN_RESET  = 60'd247786069368647760;
	localparam logic [LIM_TBL_W-1:0]  MAX_RESET  = 60'd428414119203809800;
	localparam logic [STEP_TBL_W-1:0] STEP_RESET = 48'd219945292071169;

	localparam logic [POS_W-1:0] HOME_POS [MAX_SERVOS] =
		'{10'd285, 10'd320, 10'd200, 10'd150, 10'd300, 10'd300};

	typedef enum logic [KIND_W-1:0] {
		KIND_SET  = 2'd0,
		KIND_MOVE = 2'd1,
		KIND_TICK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_MIN  = 2'd0,
		REG_MAX  = 2'd1,
		REG_STEP = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             set;
		logic             move;
		logic [ID_W-1:0]  channel;
		logic [POS_W-1:0] position;
		logic             clamp;
	} cmd_t;

	typedef struct packed {
		logic             vld;
		logic [ID_W-1:0]  servo_id;
		logic [POS_W-1:0] pulse;
		logic             last;
	} res_t;

endpackage

>>> design/msl_if.sv
// ----------------------------------------------------------------------------
// msl_if
// Valid/ready channels: command words in, pulse-width words out.
// ----------------------------------------------------------------------------
interface msl_cmd_if
	import msl_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   channel;
	logic [POS_W-1:0]  position;
	logic              clamp;

	modport source (output valid, kind, channel, position, clamp, input ready);
	modport sink   (input valid, kind, channel, position, clamp, output ready);
endinterface

interface msl_res_if
	import msl_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [ID_W-1:0]  servo_id;
	logic [POS_W-1:0] pulse;
	logic             last;

	modport source (output valid, servo_id, pulse, last, input ready);
	modport sink   (input valid, servo_id, pulse, last, output ready);
endinterface

>>> design/multi_servo_slew_limiter.sv
// ----------------------------------------------------------------------------
// multi_servo_slew_limiter
// Per-channel servo position ramp with limits, steps and a tick sweep.
// ----------------------------------------------------------------------------
// Command words enter on cmd (valid/ready): set, move or tick. Pulse-width
// words leave on res (valid/ready) as servo_id/pulse/last; last marks the
// final word of a command. Limits and step sizes sit in three 64-bit APB
// registers at 0x00, 0x08 and 0x10; pready is tied high.
// Each channel is a cell in a row. A set or move acts on its handshake; a
// set gives its word in the next cycle, a move gives none. A tick passes a
// token down the row, one cell per cycle while the row advances, and each
// busy cell emits its word as the token passes, so a tick holds the input
// until the token has left the last cell.
// A stalled receiver holds the token in place: the row only advances when
// the output register is empty or being drained, and new commands wait.
// Reset puts every channel at its home position, settled, and loads the
// default limits and steps.
// ----------------------------------------------------------------------------
`include "multi_servo_slew_limiter_macros.svh"

module multi_servo_slew_limiter
	import msl_pkg::*;
#(
	parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	msl_cmd_if.sink               cmd,
	msl_res_if.source             res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam logic [ID_W-1:0] LAST_ID = ID_W'(SERVO_COUNT - 1);

	logic [LIM_TBL_W-1:0]   min_tbl, max_tbl;
	logic [STEP_TBL_W-1:0]  step_tbl;
	logic [SERVO_COUNT-1:0] tok_vec;
	logic [SERVO_COUNT:0]   more_c;
	res_t                   res_c [SERVO_COUNT+1];

	logic             adv, busy, acc, tick_start;
	cmd_t             cmd_w;
	logic             out_valid_q;
	logic [ID_W-1:0]  servo_id_q;
	logic [POS_W-1:0] pulse_q;
	logic             last_q;

	msl_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.min_tbl  (min_tbl),
		.max_tbl  (max_tbl),
		.step_tbl (step_tbl)
	);

	assign adv        = !out_valid_q || res.ready;
	assign busy       = |tok_vec;
	assign cmd.ready  = !busy && adv;
	assign acc        = cmd.valid && cmd.ready;
	assign tick_start = acc && (cmd.kind == KIND_TICK);

	assign cmd_w = '{
		set:      acc && (cmd.kind == KIND_SET),
		move:     acc && (cmd.kind == KIND_MOVE),
		channel:  cmd.channel,
		position: cmd.position,
		clamp:    cmd.clamp
	};

	assign more_c[SERVO_COUNT] = 1'b0;
	assign res_c[0]            = '0;

	for (genvar i = 0; i < SERVO_COUNT; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = tick_start;
		end else begin : g_link
			assign tok_in = tok_vec[i-1];
		end

		msl_cell #(
			.IDX  (ID_W'(i)),
			.HOME (HOME_POS[i])
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cmd      (cmd_w),
			.lim_lo   (min_tbl[POS_W*i +: POS_W]),
			.lim_hi   (max_tbl[POS_W*i +: POS_W]),
			.step     (step_tbl[STEP_W*i +: STEP_W]),
			.tok_in   (tok_in),
			.tok_q    (tok_vec[i]),
			.more_in  (more_c[i+1]),
			.more_out (more_c[i]),
			.res_in   (res_c[i]),
			.res_out  (res_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_c[SERVO_COUNT].vld) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_c[SERVO_COUNT].vld) begin
			servo_id_q <= res_c[SERVO_COUNT].servo_id;
			pulse_q    <= res_c[SERVO_COUNT].pulse;
			last_q     <= res_c[SERVO_COUNT].last;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.servo_id = servo_id_q;
	assign res.pulse    = pulse_q;
	assign res.last     = last_q;

	`MSL_ASSERT_IMPLY(a_tok_single, clk, arst_n, 1'b1, $onehot0(tok_vec))
	`MSL_ASSERT_IMPLY(a_acc_idle, clk, arst_n, acc, tok_vec == '0)
	`MSL_ASSERT_NEXT(a_tick_enters, clk, arst_n, tick_start, tok_vec[0])
	`MSL_ASSERT_NEXT(a_set_word, clk, arst_n, cmd_w.set && (cmd.channel <= LAST_ID),
		res.valid && res.last)

endmodule

>>> design/msl_cell.sv
// ----------------------------------------------------------------------------
// msl_cell
// One servo channel: position state, clamp, per-tick step and chain links.
// ----------------------------------------------------------------------------
module msl_cell
	import msl_pkg::*;
#(
	parameter logic [ID_W-1:0]  IDX  = '0,
	parameter logic [POS_W-1:0] HOME = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  cmd_t              cmd,
	input  logic [POS_W-1:0]  lim_lo,
	input  logic [POS_W-1:0]  lim_hi,
	input  logic [STEP_W-1:0] step,
	input  logic              tok_in,
	output logic              tok_q,
	input  logic              more_in,
	output logic              more_out,
	input  res_t              res_in,
	output res_t              res_out
);

	logic [POS_W-1:0] cur_q, tgt_q;
	logic             up_q, settled_q;

	logic             hit, pending;
	logic [POS_W-1:0] lo_fix, clamped, set_pos, np;
	logic [POS_W:0]   sum, diff;

	assign hit     = cmd.channel == IDX;
	assign lo_fix  = (cmd.position < lim_lo) ? lim_lo : cmd.position;
	assign clamped = (lo_fix > lim_hi) ? lim_hi : lo_fix;
	assign set_pos = cmd.clamp ? clamped : cmd.position;

	assign pending  = !settled_q && (cur_q != tgt_q);
	assign more_out = pending || more_in;

	// no overshoot: land on target when the step would pass it
	assign sum  = {1'b0, cur_q} + {{(POS_W+1-STEP_W){1'b0}}, step};
	assign diff = {1'b0, cur_q} - {{(POS_W+1-STEP_W){1'b0}}, step};

	always_comb begin
		if (up_q) begin
			np = (sum > {1'b0, tgt_q}) ? tgt_q : sum[POS_W-1:0];
		end else begin
			np = (diff[POS_W] || (diff[POS_W-1:0] < tgt_q)) ? tgt_q : diff[POS_W-1:0];
		end
	end

	always_comb begin
		if (cmd.set && hit) begin
			res_out = '{vld: 1'b1, servo_id: IDX, pulse: set_pos, last: 1'b1};
		end else if (tok_q && adv && pending) begin
			res_out = '{vld: 1'b1, servo_id: IDX, pulse: np, last: !more_in};
		end else begin
			res_out = res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q     <= 1'b0;
			cur_q     <= HOME;
			tgt_q     <= HOME;
			up_q      <= 1'b0;
			settled_q <= 1'b1;
		end else begin
			if (adv) begin
				tok_q <= tok_in;
			end
			if (cmd.set && hit) begin
				cur_q     <= set_pos;
				tgt_q     <= set_pos;
				up_q      <= 1'b0;
				settled_q <= 1'b1;
			end else if (cmd.move && hit) begin
				tgt_q     <= clamped;
				up_q      <= clamped > cur_q;
				settled_q <= clamped == cur_q;
			end else if (tok_q && adv && !settled_q) begin
				if (cur_q == tgt_q) begin
					settled_q <= 1'b1;
				end else begin
					cur_q <= np;
				end
			end
		end
	end

endmodule

>>> design/msl_regs.sv
// ----------------------------------------------------------------------------
// msl_regs
// APB register file: lower limits, upper limits and step sizes.
// ----------------------------------------------------------------------------
module msl_regs
	import msl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LIM_TBL_W-1:0]  min_tbl,
	output logic [LIM_TBL_W-1:0]  max_tbl,
	output logic [STEP_TBL_W-1:0] step_tbl
);

	logic [LIM_TBL_W-1:0]  min_q, max_q;
	logic [STEP_TBL_W-1:0] step_q;
	logic                  wr;
	reg_idx_t              idx;

	assign pready   = 1'b1;
	assign wr       = psel && penable && pwrite;
	assign idx      = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
	assign min_tbl  = min_q;
	assign max_tbl  = max_q;
	assign step_tbl = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= MIN_RESET;
			max_q  <= MAX_RESET;
			step_q <= STEP_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_MIN:  min_q  <= pwdata[LIM_TBL_W-1:0];
				REG_MAX:  max_q  <= pwdata[LIM_TBL_W-1:0];
				REG_STEP: step_q <= pwdata[STEP_TBL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN:  prdata = {{(APB_DATA_W-LIM_TBL_W){1'b0}}, min_q};
			REG_MAX:  prdata = {{(APB_DATA_W-LIM_TBL_W){1'b0}}, max_q};
			REG_STEP: prdata = {{(APB_DATA_W-STEP_TBL_W){1'b0}}, step_q};
			default:  prdata = '0;
		endcase
	end

endmodule
